// ----- design/chacha20_stream_cipher_defines.svh -----
// assertion macros shared by the checker
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// property a implies b on the next clock
`define CC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

// property a implies b in the same clock
`define CC_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

`endif

// ----- design/cc20_pkg.sv -----
`timescale 1ns / 1ps
package cc20_pkg;

  localparam int ROUNDS = 20;
  localparam int DROUNDS = (ROUNDS + 1) / 2;
  localparam int DR_W = $clog2(DROUNDS + 1);

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [5:0] POS_MASK = 6'h3F;

  localparam logic [2:0] REG_KEY01 = 3'd0;
  localparam logic [2:0] REG_KEY23 = 3'd1;
  localparam logic [2:0] REG_KEY45 = 3'd2;
  localparam logic [2:0] REG_KEY67 = 3'd3;
  localparam logic [2:0] REG_NONCE_LO = 3'd4;
  localparam logic [2:0] REG_NONCE_HI = 3'd5;
  localparam logic [2:0] REG_COUNTER = 3'd6;

  localparam logic CMD_XOR = 1'b0;
  localparam logic CMD_SET_CTR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } cc_state_t;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;
    logic busy;
  } core_ctl_t;

  function automatic word_t rotl(input word_t v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // one quarter-round over four words packed a,b,c,d
  function automatic logic [127:0] qround(input logic [127:0] abcd);
    word_t a, b, c, d;
    a = abcd[127:96]; b = abcd[95:64]; c = abcd[63:32]; d = abcd[31:0];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qround = {a, b, c, d};
  endfunction

endpackage

// ----- design/cc20_if.sv -----
`timescale 1ns / 1ps
interface cc20_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] data_in;
  logic [31:0] new_counter;
  logic in_last;
  modport source (output valid, cmd, data_in, new_counter, in_last, input ready);
  modport sink (input valid, cmd, data_in, new_counter, in_last, output ready);
endinterface

interface cc20_out_if;
  logic valid;
  logic ready;
  logic [7:0] data_out;
  logic out_last;
  modport source (output valid, data_out, out_last, input ready);
  modport sink (input valid, data_out, out_last, output ready);
endinterface

interface cc20_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/chacha20_stream_cipher.sv -----
`timescale 1ns / 1ps
// chacha20 keystream xor over a byte stream
// channels: in (cmd, data_in, new_counter, in_last), out (data_out,
// out_last), cfg (index, data) writes key, nonce and initial counter.
// cmd xor: a data byte is xored with the next keystream byte, one result.
// cmd set counter: loads the block counter, clears byte position, no result.
// a byte at block position 0 first runs the block function: load, a
// column half and a diagonal half per double round on the quarter-round
// array, a feed-forward sweep of the 16 words into the keystream memory
// and a done flag, then the memory read and the result register. other
// bytes go straight to the memory read, then the result register.
// one request is in flight at a time.
// the result sits in the output register until taken; a stalled receiver
// holds the block, and the next request is taken once the result is gone.
// reset clears the counter, byte position and all config to zero.
module chacha20_stream_cipher
  import cc20_pkg::*;
(
  input logic clk,
  input logic rst_n,
  cc20_in_if.sink in_ch,
  cc20_out_if.source out_ch,
  cc20_cfg_if.sink cfg_ch
);

  logic [63:0] key_r [4];
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] ctr_r, ctr_nxt;
  logic [5:0] pos_r, pos_nxt;
  cc_state_t state_r, state_nxt;
  logic [7:0] din_r;
  logic last_r;
  logic [7:0] dout_r;
  logic olast_r;
  logic ovalid_r, ovalid_nxt;
  logic in_acc, out_acc, core_done;
  logic [511:0] init_state;
  logic [31:0] rd_data;
  core_ctl_t core_ctl;
  logic [7:0] ks_byte;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = ovalid_r && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;

  assign init_state = {nonce_hi_r, nonce_lo_r[63:32], nonce_lo_r[31:0], ctr_r,
                       key_r[3][63:32], key_r[3][31:0], key_r[2][63:32],
                       key_r[2][31:0], key_r[1][63:32], key_r[1][31:0],
                       key_r[0][63:32], key_r[0][31:0],
                       SIGMA3, SIGMA2, SIGMA1, SIGMA0};

  assign core_ctl.start = (state_r == ST_LOAD);
  assign core_ctl.busy = (state_r == ST_ROUND);

  cc20_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl(core_ctl), .init_state(init_state),
    .rd_addr(pos_r[5:2]), .rd_data(rd_data), .done(core_done)
  );

  always_comb begin
    case (pos_r[1:0])
      2'd0: ks_byte = rd_data[7:0];
      2'd1: ks_byte = rd_data[15:8];
      2'd2: ks_byte = rd_data[23:16];
      default: ks_byte = rd_data[31:24];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && in_ch.cmd == CMD_XOR)
                 state_nxt = (pos_r == 6'd0) ? ST_LOAD : ST_ADD;
      ST_LOAD: state_nxt = ST_ROUND;
      ST_ROUND: if (core_done) state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs / datapath control
  always_comb begin
    ctr_nxt = ctr_r;
    pos_nxt = pos_r;
    ovalid_nxt = ovalid_r && !out_acc;
    case (state_r)
      ST_IDLE: if (in_acc && in_ch.cmd == CMD_SET_CTR) begin
        ctr_nxt = in_ch.new_counter;
        pos_nxt = 6'd0;
      end
      ST_ROUND: if (core_done) ctr_nxt = ctr_r + 32'd1;
      ST_EMIT: begin
        ovalid_nxt = 1'b1;
        pos_nxt = (pos_r + 6'd1) & POS_MASK;
      end
      default: ;
    endcase
    if (cfg_ch.valid && cfg_ch.index == REG_COUNTER) begin
      ctr_nxt = cfg_ch.data[31:0];
      pos_nxt = 6'd0;
    end
  end

  // the core reads init_state through the feed-forward sweep; counter bump waits for done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r <= '0;
      pos_r <= '0;
      ovalid_r <= 1'b0;
      key_r[0] <= '0; key_r[1] <= '0; key_r[2] <= '0; key_r[3] <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r <= ctr_nxt;
      pos_r <= pos_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_KEY01: key_r[0] <= cfg_ch.data;
          REG_KEY23: key_r[1] <= cfg_ch.data;
          REG_KEY45: key_r[2] <= cfg_ch.data;
          REG_KEY67: key_r[3] <= cfg_ch.data;
          REG_NONCE_LO: nonce_lo_r <= cfg_ch.data;
          REG_NONCE_HI: nonce_hi_r <= cfg_ch.data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      din_r <= in_ch.data_in;
      last_r <= in_ch.in_last;
    end
    if (state_r == ST_EMIT) begin
      dout_r <= din_r ^ ks_byte;
      olast_r <= last_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data_out = dout_r;
  assign out_ch.out_last = olast_r;

endmodule

// ----- design/cc20_core.sv -----
`timescale 1ns / 1ps
module cc20_core
  import cc20_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  core_ctl_t    ctl,
  input  logic [511:0] init_state,
  input  logic [3:0]   rd_addr,
  output logic [31:0]  rd_data,
  output logic         done
);

  // working words live in one register file; keystream in a memory
  logic [511:0] work_r, work_nxt;
  logic [DR_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] add_idx_r, add_idx_nxt;
  logic done_r, done_nxt;
  word_t ks_mem [16];
  word_t rd_data_r;
  logic ks_we;
  word_t ks_wdata;

  function automatic word_t w(input logic [511:0] s, input int i);
    w = s[i*32 +: 32];
  endfunction

  logic [511:0] col_s, diag_s;
  logic [127:0] q0, q1, q2, q3, d0, d1, d2, d3;

  always_comb begin
    q0 = qround({w(work_r,0), w(work_r,4), w(work_r,8), w(work_r,12)});
    q1 = qround({w(work_r,1), w(work_r,5), w(work_r,9), w(work_r,13)});
    q2 = qround({w(work_r,2), w(work_r,6), w(work_r,10), w(work_r,14)});
    q3 = qround({w(work_r,3), w(work_r,7), w(work_r,11), w(work_r,15)});
    col_s = {q3[31:0], q2[31:0], q1[31:0], q0[31:0],
             q3[63:32], q2[63:32], q1[63:32], q0[63:32],
             q3[95:64], q2[95:64], q1[95:64], q0[95:64],
             q3[127:96], q2[127:96], q1[127:96], q0[127:96]};
    d0 = qround({w(work_r,0), w(work_r,5), w(work_r,10), w(work_r,15)});
    d1 = qround({w(work_r,1), w(work_r,6), w(work_r,11), w(work_r,12)});
    d2 = qround({w(work_r,2), w(work_r,7), w(work_r,8), w(work_r,13)});
    d3 = qround({w(work_r,3), w(work_r,4), w(work_r,9), w(work_r,14)});
    diag_s = {d0[31:0], d3[31:0], d2[31:0], d1[31:0],
              d1[63:32], d0[63:32], d3[63:32], d2[63:32],
              d2[95:64], d1[95:64], d0[95:64], d3[95:64],
              d3[127:96], d2[127:96], d1[127:96], d0[127:96]};
  end

  // phase 0 idle, 1 column half, 2 diagonal half, 3 feed-forward sweep
  always_comb begin
    work_nxt = work_r;
    cnt_nxt = cnt_r;
    phase_nxt = phase_r;
    add_idx_nxt = add_idx_r;
    done_nxt = 1'b0;
    ks_we = 1'b0;
    ks_wdata = w(work_r, int'(add_idx_r)) + w(init_state, int'(add_idx_r));
    case (phase_r)
      2'd0: begin
        if (ctl.start) begin
          work_nxt = init_state;
          cnt_nxt = DR_W'(DROUNDS);
          phase_nxt = (DROUNDS > 0) ? 2'd1 : 2'd3;
          add_idx_nxt = 4'd0;
        end
      end
      2'd1: begin
        work_nxt = col_s;
        phase_nxt = 2'd2;
      end
      2'd2: begin
        work_nxt = diag_s;
        cnt_nxt = cnt_r - 1'b1;
        phase_nxt = (cnt_r == DR_W'(1)) ? 2'd3 : 2'd1;
      end
      2'd3: begin
        ks_we = 1'b1;
        add_idx_nxt = add_idx_r + 1'b1;
        if (add_idx_r == 4'hF) begin
          phase_nxt = 2'd0;
          done_nxt = 1'b1;
        end
      end
      default: phase_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      done_r <= 1'b0;
      cnt_r <= '0;
      add_idx_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
      add_idx_r <= add_idx_nxt;
    end
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (ks_we) ks_mem[add_idx_r] <= ks_wdata;
    rd_data_r <= ks_mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign done = done_r;

endmodule

// ----- design/cc20_checker.sv -----
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_defines.svh"
module cc20_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_data
);
  `CC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
  `CC_ASSERT_NOW(a_no_accept_busy, clk, rst_n, out_valid, !in_ready, "request taken while result pending")
  `CC_ASSERT_NEXT(a_set_ctr_silent, clk, rst_n, in_valid && in_ready && in_cmd, !out_valid, "set counter gave a result")
  `CC_ASSERT_NEXT(a_ready_after_accept, clk, rst_n, in_valid && in_ready, !in_ready || in_cmd == 1'b1 || !out_valid, "ready reasserted while busy")
endmodule

bind chacha20_stream_cipher cc20_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_cmd(in_ch.cmd), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data_out)
);

// ----- dv/chacha20_stream_cipher_tb.sv -----
`timescale 1ns / 1ps
module chacha20_stream_cipher_tb;
  import cc20_pkg::*;

  typedef struct {
    logic        cmd;
    logic [7:0]  data;
    logic [31:0] ctr;
    logic        last;
  } cipher_req_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } cipher_byte_t;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 80;

  logic clk;
  logic rst_n;

  cc20_in_if in_ch ();
  cc20_out_if out_ch ();
  cc20_cfg_if cfg_ch ();

  chacha20_stream_cipher dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted cipher state
  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] blk_ctr;
  logic [5:0]  byte_pos;
  word_t       ks_words [16];
  word_t       mix [16];

  cipher_req_t  pending_reqs [$];
  cipher_byte_t expected_bytes [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int idle_cycles;
  int n_bytes, n_set_ctr, n_blocks, n_cfg, n_wraps;

  function automatic word_t rot32(word_t v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function void quarter(int a, int b, int c, int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 7);
  endfunction

  function void make_keystream_block();
    word_t init [16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2 * k] = key_reg[k][31:0];
      init[5 + 2 * k] = key_reg[k][63:32];
    end
    init[12] = blk_ctr;
    init[13] = nonce_lo[31:0];
    init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
    mix = init;
    // odd round counts behave as the next even one
    for (int left = ROUNDS; left > 0; left -= 2) begin
      quarter(0, 4, 8, 12);
      quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14);
      quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15);
      quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13);
      quarter(3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) ks_words[k] = mix[k] + init[k];
  endfunction

  function void predict_cipher(cipher_req_t r);
    cipher_byte_t e;
    logic [7:0] ks;
    if (r.cmd == CMD_SET_CTR) begin
      blk_ctr = r.ctr;
      byte_pos = '0;
      n_set_ctr++;
    end else begin
      if (byte_pos == 0) begin
        make_keystream_block();
        if (blk_ctr == 32'hFFFF_FFFF) n_wraps++;
        blk_ctr = blk_ctr + 32'd1;
        n_blocks++;
      end
      ks = 8'(ks_words[byte_pos[5:2]] >> (8 * byte_pos[1:0]));
      e.data = r.data ^ ks;
      e.last = r.last;
      expected_bytes.push_back(e);
      byte_pos = byte_pos + 6'd1;
      n_bytes++;
    end
  endfunction

  function void apply_cfg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67: begin
        key_reg[idx[1:0]] = val;
      end
      REG_NONCE_LO: begin
        nonce_lo = val;
      end
      REG_NONCE_HI: begin
        nonce_hi = val[31:0];
      end
      REG_COUNTER: begin
        blk_ctr = val[31:0];
        byte_pos = '0;
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_cipher(pending_reqs.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= pending_reqs[0].cmd;
          in_ch.data_in <= pending_reqs[0].data;
          in_ch.new_counter <= pending_reqs[0].ctr;
          in_ch.in_last <= pending_reqs[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cipher_byte_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: data_out=%02h out_last=%0b",
                     out_ch.data_out, out_ch.out_last);
        end else begin
          e = expected_bytes.pop_front();
          if (out_ch.data_out !== e.data || out_ch.out_last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: data_out exp %02h got %02h, out_last exp %0b got %0b",
                       e.data, out_ch.data_out, e.last, out_ch.out_last);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("chacha20_stream_cipher_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_cfg(idx, val);
    n_cfg++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_req(logic cmd, logic [7:0] data, logic [31:0] ctr, logic last);
    cipher_req_t r;
    r.cmd = cmd;
    r.data = data;
    r.ctr = ctr;
    r.last = last;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] pick_counter();
    case ($urandom_range(4))
      0: return 32'hFFFF_FFFF;
      1: return 32'hFFFF_FFFE;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // mostly a counter load followed by a run of bytes, some noise
  task automatic add_random_reqs(int count);
    int made;
    int run;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) < 8) begin
        add_req(CMD_SET_CTR, 8'($urandom), pick_counter(), 1'($urandom));
        run = ($urandom_range(3) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 40);
        for (int k = 0; k < run; k++)
          add_req(CMD_XOR, 8'($urandom), $urandom, $urandom_range(7) == 0);
        made += run + 1;
      end else begin
        run = $urandom_range(1, 4);
        for (int k = 0; k < run; k++)
          add_req(1'($urandom), 8'($urandom), $urandom, 1'($urandom));
        made += run;
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_bytes.size() > 0 || in_ch.valid)
      @(posedge clk);
    // a trailing counter load may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_XOR;
    in_ch.data_in = '0;
    in_ch.new_counter = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatches = 0;
    idle_cycles = 0;
    n_bytes = 0; n_set_ctr = 0; n_blocks = 0; n_cfg = 0; n_wraps = 0;
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    nonce_lo = '0;
    nonce_hi = '0;
    blk_ctr = '0;
    byte_pos = '0;
    send_idle_pct = 11;
    recv_idle_pct = 85;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all-zero config, field extremes, counter wrap via loads
    add_req(CMD_XOR, 8'h00, 32'h0, 1'b0);
    add_req(CMD_XOR, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_req(CMD_XOR, 8'h55, 32'h0, 1'b0);
    add_req(CMD_XOR, 8'hAA, 32'h0, 1'b1);
    add_req(CMD_SET_CTR, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_req(CMD_XOR, 8'h01, 32'h0, 1'b0);
    add_req(CMD_XOR, 8'h80, 32'h0, 1'b1);
    add_req(CMD_SET_CTR, 8'h00, 32'h0, 1'b0);
    add_req(CMD_SET_CTR, 8'h12, 32'h8000_0001, 1'b0);
    add_req(CMD_XOR, 8'h7F, 32'h0, 1'b0);
    add_req(CMD_SET_CTR, 8'h00, 32'h0000_0001, 1'b1);
    for (int k = 0; k < 10; k++) add_req(CMD_XOR, 8'($urandom), $urandom, k[0]);
    add_random_reqs(130);
    drain();

    // all registers random, plus an unused index
    for (int i = REG_KEY01; i <= REG_COUNTER; i++) cfg_write(3'(i), {$urandom, $urandom});
    cfg_write(3'd7, {$urandom, $urandom});
    add_random_reqs(150);
    drain();

    // key and nonce all ones mid-block: counter untouched
    send_idle_pct = 85;
    recv_idle_pct = 11;
    for (int i = REG_KEY01; i <= REG_NONCE_HI; i++) cfg_write(3'(i), '1);
    add_random_reqs(150);
    drain();

    // zero key and nonce, counter about to wrap
    for (int i = REG_KEY01; i <= REG_NONCE_HI; i++) cfg_write(3'(i), '0);
    cfg_write(REG_COUNTER, 64'hFFFF_FFFF);
    for (int k = 0; k < 70; k++) add_req(CMD_XOR, 8'($urandom), 32'h0, 1'($urandom));
    add_random_reqs(80);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = REG_KEY01; i <= REG_COUNTER; i++) cfg_write(3'(i), {$urandom, $urandom});
    add_random_reqs(150);
    drain();

    $display("covered %0d bytes, %0d counter loads, %0d blocks (%0d counter wraps)",
             n_bytes, n_set_ctr, n_blocks, n_wraps);
    $display("%0d register writes across five settings, %0d mismatches",
             n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("chacha20_stream_cipher_tb OK");
    end else begin
      $display("chacha20_stream_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule
